// ----- design/aotg_pkg.sv -----
// Shared types, constants and elaboration-time tables for the organ tone generator.
// Holds the sine ROM builder and the harmonic weight builder.
// No dependencies; every other design file refers to it by scoped names.
package aotg_pkg;

  // Tone structure
  localparam int HARMONICS  = 8;
  localparam int SINE_DEPTH = 1024;
  localparam int IDX_W      = $clog2(SINE_DEPTH);
  localparam int HARM_W     = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int STEP_W     = $clog2(2 * HARMONICS);

  // Fixed-point constants
  localparam logic [31:0] DETUNE_Q24  = 32'd16878886;  // 1.00606 in Q24
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Configuration
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = CFG_INDEX_W'(1);

  localparam int PHASE_STEP_W = 31;
  localparam int AMP_W        = 15;
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = PHASE_STEP_W'(42800000);
  localparam logic [AMP_W-1:0]        AMP_RESET        = AMP_W'(16384);
  localparam logic [31:0] DET_STEP_RESET =
    32'((64'(PHASE_STEP_RESET) * 64'(DETUNE_Q24) + 64'd8388608) >> 24);

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Datapath widths
  localparam int SINE_W   = 17;                   // Q15, peak +/-32768
  localparam int WEIGHT_W = 31;                   // Q30, at most 2^30
  localparam int PROD_W   = WEIGHT_W + 1 + SINE_W;
  localparam int ACC_W    = PROD_W + STEP_W;
  localparam int RND_W    = ACC_W - 18;           // after rounding shift by 20
  localparam int SC_W     = RND_W + AMP_W + 1;
  localparam int OUT_W    = SC_W - 24;            // after rounding shift by 26
  localparam int SAMPLE_W = 16;

  typedef logic signed [SINE_W-1:0] sine_word_t;
  typedef sine_word_t [SINE_DEPTH-1:0] sine_rom_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef weight_t [HARMONICS-1:0] weight_tab_t;

  // One sample's work: the two oscillator phases at the fundamental
  typedef struct packed {
    logic [31:0] base_phase;
    logic [31:0] detuned_phase;
  } osc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_SCALE,
    ST_DONE
  } back_state_t;

  // First-quadrant sine by a Taylor sum up to x^17, terms truncated in Q30
  function automatic sine_word_t quarter_sine(input logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] mag;
    x = (64'(r) * 64'(HALF_PI_Q30) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    mag = ($unsigned(sum) * 64'd32768 + 64'd536870912) >> 30;
    return sine_word_t'(mag[SINE_W-1:0]);
  endfunction

  // Full-cycle table, folded from the first quadrant
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [31:0] q4;
    logic [31:0] quad;
    logic [31:0] rem;
    logic [31:0] r;
    sine_word_t s;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      q4   = 32'(i) * 32'd4;
      quad = q4 / 32'(SINE_DEPTH);
      rem  = q4 % 32'(SINE_DEPTH);
      r    = quad[0] ? (32'(SINE_DEPTH) - rem) : rem;
      s    = quarter_sine(r);
      rom[i] = quad[1] ? -s : s;
    end
    return rom;
  endfunction

  // Harmonic weights in Q30: fundamental gets 0.9^(H-1), the rest 0.1*0.9^(H-k)
  function automatic weight_tab_t build_weights();
    weight_tab_t w;
    logic [63:0] p [0:HARMONICS];
    p[0] = 64'd1 << 30;
    for (int i = 1; i <= HARMONICS; i++) begin
      p[i] = (p[i-1] * 64'd9 + 64'd5) / 64'd10;
    end
    w[0] = WEIGHT_W'(p[HARMONICS-1]);
    for (int i = 1; i < HARMONICS; i++) begin
      w[i] = WEIGHT_W'((p[HARMONICS-i] + 64'd5) / 64'd10);
    end
    return w;
  endfunction

endpackage

// ----- design/aotg_front.sv -----
// Front end of the organ tone generator: configuration registers, input beats
// and both phase accumulators. Pushes one phase pair per beat into the queue.
// Depends on aotg_pkg.
module aotg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aotg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aotg_pkg::PHASE_STEP_W-1:0]    cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output aotg_pkg::osc_cmd_t                   push_cmd,
  output logic [aotg_pkg::AMP_W-1:0]           amplitude
);

  logic [aotg_pkg::PHASE_STEP_W-1:0] phase_step;
  logic [31:0] det_step;
  logic [31:0] base_phase;
  logic [31:0] detuned_phase;
  logic [55:0] det_prod;
  logic [55:0] det_sum;
  logic [31:0] det_step_next;
  logic [31:0] cur_base;
  logic [31:0] cur_det;
  logic        accept;

  assign cfg_ready = 1'b1;

  // Detuned step follows the written value in the same edge
  always_comb begin
    det_prod      = 56'(cfg_data) * 56'(aotg_pkg::DETUNE_Q24);
    det_sum       = det_prod + 56'd8388608;
    det_step_next = det_sum[55:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= aotg_pkg::PHASE_STEP_RESET;
      det_step   <= aotg_pkg::DET_STEP_RESET;
      amplitude  <= aotg_pkg::AMP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        aotg_pkg::REG_PHASE_STEP: begin
          phase_step <= cfg_data;
          det_step   <= det_step_next;
        end
        aotg_pkg::REG_AMPLITUDE: begin
          amplitude <= cfg_data[aotg_pkg::AMP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Restart zeroes both phases before this beat's sample
  assign accept     = s_tvalid && push_ready;
  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign cur_base   = s_tdata[0] ? 32'd0 : base_phase;
  assign cur_det    = s_tdata[0] ? 32'd0 : detuned_phase;
  assign push_cmd.base_phase    = cur_base;
  assign push_cmd.detuned_phase = cur_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_phase    <= 32'd0;
      detuned_phase <= 32'd0;
    end else if (accept) begin
      base_phase    <= cur_base + 32'(phase_step);
      detuned_phase <= cur_det + det_step;
    end
  end

endmodule

// ----- design/aotg_queue.sv -----
// Short command queue between the front end and the synthesis engine.
// Depends on aotg_pkg for the entry type and depth.
module aotg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  aotg_pkg::osc_cmd_t push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output aotg_pkg::osc_cmd_t pop_cmd
);

  aotg_pkg::osc_cmd_t entries [aotg_pkg::QUEUE_DEPTH];
  logic [aotg_pkg::QPTR_W-1:0] wr_ptr;
  logic [aotg_pkg::QPTR_W-1:0] rd_ptr;
  logic [aotg_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != aotg_pkg::QCNT_W'(aotg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == aotg_pkg::QPTR_W'(aotg_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == aotg_pkg::QPTR_W'(aotg_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/aotg_back.sv -----
// Synthesis engine: walks all harmonics of both oscillators through one sine ROM
// port and one multiplier, then rounds, scales, saturates and holds the sample.
// Depends on aotg_pkg.
module aotg_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  aotg_pkg::osc_cmd_t             pop_cmd,
  input  logic [aotg_pkg::AMP_W-1:0]     amplitude,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [aotg_pkg::SAMPLE_W-1:0]  m_tdata
);

  localparam aotg_pkg::sine_rom_t   SINE_ROM = aotg_pkg::build_sine_rom();
  localparam aotg_pkg::weight_tab_t WEIGHTS  = aotg_pkg::build_weights();
  localparam int ACC_W = aotg_pkg::ACC_W;
  localparam int RND_W = aotg_pkg::RND_W;
  localparam int SC_W  = aotg_pkg::SC_W;
  localparam int OUT_W = aotg_pkg::OUT_W;

  aotg_pkg::back_state_t state;
  aotg_pkg::back_state_t state_next;

  logic pop;
  logic issue;
  logic load_out;
  logic last_step;

  logic [aotg_pkg::HARM_W-1:0] hcnt;
  logic                        sel;
  logic [31:0] base_inc;
  logic [31:0] det_inc;
  logic [31:0] hb;
  logic [31:0] hd;
  logic [aotg_pkg::IDX_W-1:0] rom_idx;

  logic                             v1;
  logic                             v2;
  aotg_pkg::sine_word_t             rom_q;
  logic [aotg_pkg::HARM_W-1:0]      hq1;
  logic signed [aotg_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]          acc;
  logic signed [RND_W-1:0]          rnd;
  logic signed [SC_W-1:0]           scaled;

  logic                   acc_neg;
  logic [ACC_W-1:0]       acc_mag;
  logic [ACC_W:0]         acc_sum;
  logic signed [RND_W-1:0] rnd_next;
  logic                   sc_neg;
  logic [SC_W-1:0]        sc_mag;
  logic [SC_W:0]          sc_sum;
  logic signed [OUT_W-1:0] r2;
  logic [aotg_pkg::SAMPLE_W-1:0] sample_next;
  logic                   out_valid;
  logic [aotg_pkg::SAMPLE_W-1:0] out_data;

  assign last_step = sel && (hcnt == aotg_pkg::HARM_W'(aotg_pkg::HARMONICS - 1));
  assign pop_ready = pop;
  assign rom_idx   = sel ? hd[31 -: aotg_pkg::IDX_W] : hb[31 -: aotg_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aotg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      aotg_pkg::ST_IDLE: begin
        if (pop_valid) begin
          pop        = 1'b1;
          state_next = aotg_pkg::ST_RUN;
        end
      end
      aotg_pkg::ST_RUN: begin
        issue = 1'b1;
        if (last_step) begin
          state_next = aotg_pkg::ST_DRAIN;
        end
      end
      aotg_pkg::ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = aotg_pkg::ST_ROUND;
        end
      end
      aotg_pkg::ST_ROUND: begin
        state_next = aotg_pkg::ST_SCALE;
      end
      aotg_pkg::ST_SCALE: begin
        state_next = aotg_pkg::ST_DONE;
      end
      aotg_pkg::ST_DONE: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = aotg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aotg_pkg::ST_IDLE;
      end
    endcase
  end

  // Harmonic phases: phase*k built by repeated addition, modulo 2^32
  always_ff @(posedge clk) begin
    if (pop) begin
      base_inc <= pop_cmd.base_phase;
      det_inc  <= pop_cmd.detuned_phase;
      hb       <= pop_cmd.base_phase;
      hd       <= pop_cmd.detuned_phase;
      hcnt     <= '0;
      sel      <= 1'b0;
    end else if (issue) begin
      sel <= ~sel;
      if (sel) begin
        hcnt <= hcnt + 1'b1;
        hb   <= hb + base_inc;
        hd   <= hd + det_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // ROM read, weight multiply, accumulate
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_idx];
    hq1   <= hcnt;
    prod  <= $signed({1'b0, WEIGHTS[hq1]}) * rom_q;
    if (pop) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Rounding shifts, half away from zero
  always_comb begin
    acc_neg  = acc[ACC_W-1];
    acc_mag  = acc_neg ? $unsigned(-acc) : $unsigned(acc);
    acc_sum  = {1'b0, acc_mag} + (ACC_W + 1)'(1 << 19);
    rnd_next = acc_neg ? -$signed({1'b0, acc_sum[ACC_W:20]})
                       :  $signed({1'b0, acc_sum[ACC_W:20]});
    sc_neg   = scaled[SC_W-1];
    sc_mag   = sc_neg ? $unsigned(-scaled) : $unsigned(scaled);
    sc_sum   = {1'b0, sc_mag} + (SC_W + 1)'(1 << 25);
    r2       = sc_neg ? -$signed({1'b0, sc_sum[SC_W:26]})
                      :  $signed({1'b0, sc_sum[SC_W:26]});
    if (r2 > $signed(OUT_W'(32767))) begin
      sample_next = 16'h7FFF;
    end else if (r2 < -$signed(OUT_W'(32768))) begin
      sample_next = 16'h8000;
    end else begin
      sample_next = r2[aotg_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == aotg_pkg::ST_ROUND) begin
      rnd <= rnd_next;
    end
    if (state == aotg_pkg::ST_SCALE) begin
      scaled <= rnd * $signed({1'b0, amplitude});
    end
    if (load_out) begin
      out_data <= sample_next;
    end
  end

  // Output register: hold until the receiver takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- design/additive_organ_tone_generator.sv -----
// Top level of the additive organ tone generator.
// Ties the front end, the command queue and the synthesis engine together.
// Depends on aotg_pkg, aotg_front, aotg_queue and aotg_back.
//
// Usage:
//   Each input beat on s_* asks for one output sample on m_*. Bit 0 of s_tdata
//   is the restart flag: when set, both oscillator phases are zeroed before the
//   sample is taken, so a new note begins in phase.
//   The configuration channel (cfg_*) writes phase_step (index 0, base tone
//   increment per sample) and amplitude (index 1). Other indexes are dropped.
//   Write it only while no beat is in flight.
//   Input beats pass into a two-deep queue, so the front keeps accepting while
//   the engine works or while a finished sample waits on m_tdata.
//   Sample throughput is set by the single sine ROM port and weight multiplier,
//   which handle one oscillator of one harmonic per cycle.
//   Reset (rst, synchronous) restores phase_step 42800000 and amplitude 16384,
//   zeroes both phases and empties the queue and the output register.
//   If the receiver stalls, the sample is held on m_tdata, the engine waits
//   with its next result, and s_tready drops once the queue is full.
module additive_organ_tone_generator (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aotg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aotg_pkg::PHASE_STEP_W-1:0] cfg_data,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata    // [15:0] sample, signed
);

  logic               push_valid;
  logic               push_ready;
  aotg_pkg::osc_cmd_t push_cmd;
  logic               pop_valid;
  logic               pop_ready;
  aotg_pkg::osc_cmd_t pop_cmd;
  logic [aotg_pkg::AMP_W-1:0] amplitude;

  // Accept beats, hold config, advance the phase accumulators
  aotg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .amplitude  (amplitude)
  );

  // Decouple the front from the engine
  aotg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Sum all harmonics, scale, saturate and present the sample
  aotg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .amplitude (amplitude),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
